FILE: src/tes_pkg.sv
// Shared types and constants for the tuple element splitter.
`default_nettype none

package tes_pkg;

    localparam int unsigned MAX_TUPLE_BYTES_DEF = 65536;
    localparam logic [3:0]  STAMP_BYTES         = 4'd12;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned TYPE_W = 4;
    localparam int unsigned CNT_W  = 17;

    localparam int unsigned RECS_MAX = 3;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        REC_ELEM = 2'd0,
        REC_DONE = 2'd1,
        REC_BAD  = 2'd2
    } rec_kind_t;

    localparam logic [TYPE_W-1:0] TY_NULL   = 4'd0;
    localparam logic [TYPE_W-1:0] TY_BYTES  = 4'd1;
    localparam logic [TYPE_W-1:0] TY_UTF8   = 4'd2;
    localparam logic [TYPE_W-1:0] TY_INT    = 4'd3;
    localparam logic [TYPE_W-1:0] TY_FLOAT  = 4'd4;
    localparam logic [TYPE_W-1:0] TY_DOUBLE = 4'd5;
    localparam logic [TYPE_W-1:0] TY_BOOL   = 4'd6;
    localparam logic [TYPE_W-1:0] TY_STAMP  = 4'd7;
    localparam logic [TYPE_W-1:0] TY_USER   = 4'd8;

    typedef struct packed {
        rec_kind_t          kind;
        logic [OFF_W-1:0]   offset;
        logic [TYPE_W-1:0]  etype;
        logic               complete;
        logic [CNT_W-1:0]   count;
    } rec_t;

    // All results caused by one input beat, oldest in slot 0.
    typedef struct packed {
        logic [1:0]          n;
        rec_t [RECS_MAX-1:0] rec;
    } bundle_t;

endpackage

`default_nettype wire

FILE: src/tes_front.sv
// Parser front end: walks the byte stream and bundles the records of each beat.
`default_nettype none

module tes_front import tes_pkg::*; #(
    parameter int unsigned MAX_TUPLE_BYTES = MAX_TUPLE_BYTES_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_accept,
    input  wire logic [7:0] in_byte,
    input  wire logic    in_eoi,
    input  wire logic    drop_incomplete,
    input  wire logic    allow_user_type,
    output logic         push,
    output bundle_t      push_data
);

    localparam int unsigned POS_W = $clog2(MAX_TUPLE_BYTES + 1);

    localparam logic [7:0] CODE_NULL     = 8'h00;
    localparam logic [7:0] CODE_BYTES    = 8'h01;
    localparam logic [7:0] CODE_UTF8     = 8'h02;
    localparam logic [7:0] CODE_INT_LO   = 8'h0C;
    localparam logic [7:0] CODE_INT_ZERO = 8'h14;
    localparam logic [7:0] CODE_INT_HI   = 8'h1C;
    localparam logic [7:0] CODE_FLOAT    = 8'h20;
    localparam logic [7:0] CODE_DOUBLE   = 8'h21;
    localparam logic [7:0] CODE_FALSE    = 8'h26;
    localparam logic [7:0] CODE_TRUE     = 8'h27;
    localparam logic [7:0] CODE_STAMP    = 8'h33;
    localparam logic [7:0] CODE_USER_LO  = 8'h40;
    localparam logic [7:0] CODE_USER_HI  = 8'h4F;
    localparam logic [7:0] ESC_BYTE      = 8'hFF;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_CODE, PH_FIXED, PH_STR, PH_STRZ, PH_USER, PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {DC_FIXED, DC_STR, DC_USER, DC_BAD} dec_kind_t;

    typedef struct packed {
        dec_kind_t         kind;
        logic [TYPE_W-1:0] etype;
        logic [3:0]        len;
    } dec_t;

    function automatic dec_t decode_code(input logic [7:0] b, input logic allow_user);
        dec_t d;
        d.kind  = DC_BAD;
        d.etype = TY_NULL;
        d.len   = 4'd0;
        if (b == CODE_NULL) begin
            d.kind = DC_FIXED;
        end else if (b == CODE_BYTES) begin
            d.kind  = DC_STR;
            d.etype = TY_BYTES;
        end else if (b == CODE_UTF8) begin
            d.kind  = DC_STR;
            d.etype = TY_UTF8;
        end else if (b >= CODE_INT_LO && b <= CODE_INT_HI) begin
            d.kind  = DC_FIXED;
            d.etype = TY_INT;
            d.len   = (b >= CODE_INT_ZERO) ? 4'(b - CODE_INT_ZERO) : 4'(CODE_INT_ZERO - b);
        end else if (b == CODE_FLOAT) begin
            d.kind  = DC_FIXED;
            d.etype = TY_FLOAT;
            d.len   = 4'd4;
        end else if (b == CODE_DOUBLE) begin
            d.kind  = DC_FIXED;
            d.etype = TY_DOUBLE;
            d.len   = 4'd8;
        end else if (b == CODE_FALSE || b == CODE_TRUE) begin
            d.kind  = DC_FIXED;
            d.etype = TY_BOOL;
        end else if (b == CODE_STAMP) begin
            d.kind  = DC_FIXED;
            d.etype = TY_STAMP;
            d.len   = STAMP_BYTES;
        end else if (allow_user && b >= CODE_USER_LO && b <= CODE_USER_HI) begin
            d.kind  = DC_USER;
            d.etype = TY_USER;
        end
        return d;
    endfunction

    phase_t             phase_reg, phase_mid, phase_next;
    logic [3:0]         left_reg, left_mid, left_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [OFF_W-1:0]   start_reg, start_mid, start_next;
    logic [TYPE_W-1:0]  type_reg, type_mid, type_next;
    logic               body_reg, body_mid, body_next;
    logic [CNT_W-1:0]   total_reg, total_next, total_step;

    logic               take;
    logic               start;
    dec_t               dec;
    logic [OFF_W-1:0]   pos_off;
    logic [3:0]         left_dec;

    assign take     = pos_reg < POS_W'(MAX_TUPLE_BYTES);
    assign dec      = decode_code(in_byte, allow_user_type);
    assign pos_off  = OFF_W'(pos_reg);
    assign left_dec = (left_reg != 4'd0) ? left_reg - 4'd1 : left_reg;
    // A type code is read in the code phase, or right after a string terminator.
    assign start    = take && (phase_reg == PH_CODE ||
                               (phase_reg == PH_STRZ && in_byte != ESC_BYTE));

    // Next state: first the effect of the byte, then the end flag clears the tuple.
    always_comb begin
        phase_mid = phase_reg;
        left_mid  = left_reg;
        start_mid = start_reg;
        type_mid  = type_reg;
        body_mid  = body_reg;
        if (start) begin
            start_mid = pos_off;
            unique case (dec.kind)
                DC_FIXED: begin
                    type_mid = dec.etype;
                    if (dec.len == 4'd0) begin
                        phase_mid = PH_CODE;
                    end else begin
                        left_mid  = dec.len;
                        phase_mid = PH_FIXED;
                    end
                end
                DC_STR: begin
                    type_mid  = dec.etype;
                    body_mid  = 1'b0;
                    phase_mid = PH_STR;
                end
                DC_USER: begin
                    type_mid  = TY_USER;
                    phase_mid = PH_USER;
                end
                DC_BAD: begin
                    phase_mid = PH_SKIP;
                end
            endcase
        end else if (take) begin
            case (phase_reg)
                PH_FIXED: begin
                    left_mid = left_dec;
                    if (left_dec == 4'd0) begin
                        phase_mid = PH_CODE;
                    end
                end
                PH_STR: begin
                    if (in_byte == CODE_NULL) begin
                        phase_mid = PH_STRZ;
                    end else begin
                        body_mid = 1'b1;
                    end
                end
                PH_STRZ: begin
                    // escaped zero: back into the string body
                    phase_mid = PH_STR;
                    body_mid  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        type_next  = type_reg;
        body_next  = body_reg;
        if (in_accept) begin
            if (in_eoi) begin
                phase_next = PH_CODE;
                left_next  = 4'd0;
                pos_next   = '0;
                start_next = '0;
                type_next  = TY_NULL;
                body_next  = 1'b0;
            end else begin
                phase_next = phase_mid;
                left_next  = left_mid;
                pos_next   = take ? pos_reg + POS_W'(1) : pos_reg;
                start_next = start_mid;
                type_next  = type_mid;
                body_next  = body_mid;
            end
        end
    end

    // Outputs: up to four candidate records in stream order, compacted into the bundle.
    always_comb begin
        rec_t        cand [4];
        logic [3:0]  cv;
        logic [1:0]  n;
        bundle_t     b;

        for (int k = 0; k < 4; k++) begin
            cand[k] = '{kind: REC_ELEM, offset: '0, etype: TY_NULL, complete: 1'b0,
                        count: '0};
        end
        cv = 4'b0000;
        total_step = total_reg;

        // string closed by a terminator followed by a non-escape byte
        if (take && phase_reg == PH_STRZ && in_byte != ESC_BYTE) begin
            cv[0] = 1'b1;
            cand[0].offset   = start_reg;
            cand[0].etype    = type_reg;
            cand[0].complete = 1'b1;
        end

        if (start) begin
            if ((dec.kind == DC_FIXED && dec.len == 4'd0) || dec.kind == DC_USER) begin
                cv[1] = 1'b1;
                cand[1].offset   = pos_off;
                cand[1].etype    = dec.etype;
                cand[1].complete = 1'b1;
            end else if (dec.kind == DC_BAD) begin
                cv[1] = 1'b1;
                cand[1].kind   = REC_BAD;
                cand[1].offset = {{(OFF_W - 8){1'b0}}, in_byte};
            end
        end else if (take && phase_reg == PH_FIXED && left_dec == 4'd0) begin
            cv[1] = 1'b1;
            cand[1].offset   = start_reg;
            cand[1].etype    = type_reg;
            cand[1].complete = 1'b1;
        end

        if (in_eoi) begin
            cand[2].offset = start_mid;
            cand[2].etype  = type_mid;
            case (phase_mid)
                PH_FIXED: begin
                    cv[2] = !drop_incomplete;
                    cand[2].complete = 1'b0;
                end
                PH_STR: begin
                    cv[2] = body_mid || !drop_incomplete;
                    cand[2].complete = body_mid;
                end
                PH_STRZ: begin
                    cv[2] = 1'b1;
                    cand[2].complete = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // count reported elements, saturating
        for (int k = 0; k < 3; k++) begin
            if (cv[k] && cand[k].kind == REC_ELEM && total_step != CNT_SAT) begin
                total_step = total_step + CNT_W'(1);
            end
        end

        if (in_eoi && phase_mid != PH_SKIP) begin
            cv[3] = 1'b1;
            cand[3].kind  = REC_DONE;
            cand[3].count = total_step;
        end

        n = 2'd0;
        b = '0;
        for (int k = 0; k < 4; k++) begin
            if (cv[k] && n != 2'd3) begin
                b.rec[n] = cand[k];
                n = n + 2'd1;
            end
        end
        b.n = n;
        push_data = b;
    end

    assign push = in_accept && (push_data.n != 2'd0);

    always_comb begin
        total_next = total_reg;
        if (in_accept) begin
            total_next = in_eoi ? '0 : total_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CODE;
            left_reg  <= 4'd0;
            pos_reg   <= '0;
            start_reg <= '0;
            type_reg  <= TY_NULL;
            body_reg  <= 1'b0;
            total_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            type_reg  <= type_next;
            body_reg  <= body_next;
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tes_fifo.sv
// Short bundle queue between the parser and the result serialiser.
`default_nettype none

module tes_fifo import tes_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output logic         full,
    output logic         empty,
    output bundle_t      head
);

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tes_back.sv
// Result serialiser: unpacks each bundle into one output beat per record.
`default_nettype none

module tes_back import tes_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    empty,
    input  wire bundle_t head,
    output logic         pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [KIND_W-1:0] m_rec_kind,
    output logic [OFF_W-1:0]  m_elem_offset,
    output logic [TYPE_W-1:0] m_elem_type,
    output logic              m_elem_complete,
    output logic [CNT_W-1:0]  m_elem_count,
    output logic              m_run_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    rec_t       rec_reg, sel;
    logic       last_reg, last;
    logic       load;

    assign load = !empty && (!valid_reg || m_ready);
    assign last = (2'(idx_reg + 2'd1) == head.n);
    assign pop  = load && last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel = head.rec[0];
            2'd1:    sel = head.rec[1];
            default: sel = head.rec[2];
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // hold the beat while the receiver stalls
    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg  <= sel;
            last_reg <= last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_rec_kind      = rec_reg.kind;
    assign m_elem_offset   = rec_reg.offset;
    assign m_elem_type     = rec_reg.etype;
    assign m_elem_complete = rec_reg.complete;
    assign m_elem_count    = rec_reg.count;
    assign m_run_last      = last_reg;

endmodule

`default_nettype wire

FILE: src/tuple_element_splitter_top.sv
// Top level of the tuple element splitter.
//
// Input beats carry one byte of a packed, type-coded key plus an end flag
// (s_valid/s_ready). Each element found comes out as one result beat on the
// m_ channel with its start offset, type class and completeness; a done beat
// with the element count closes each tuple that had no unknown code, and an
// unknown code gives an error beat after which the rest of that tuple is
// skipped. m_run_last marks the final result caused by a given input byte.
// One input byte is taken per cycle while s_ready is high. The results
// of a byte pass through the queue and the output register before they
// show on m_valid. A byte causing several results holds the result port
// for one beat per result; the parser keeps running into a four-entry queue
// of per-byte bundles and s_ready falls only when that queue is full.
// When the receiver stalls, the output beat is held stable and the queue
// absorbs further bytes until full. Reset (aresetn low, synchronous) clears
// the parser, queue and both configuration bits. Configuration is written
// through cfg_wr_en/cfg_index/cfg_data, one register per cycle; the user
// must write it only while the block is idle; it does not enforce this.
`default_nettype none

module tuple_element_splitter_top import tes_pkg::*; #(
    parameter int unsigned MAX_TUPLE_BYTES = MAX_TUPLE_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_end_of_input,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [KIND_W-1:0]      m_rec_kind,
    output logic [OFF_W-1:0]       m_elem_offset,
    output logic [TYPE_W-1:0]      m_elem_type,
    output logic                   m_elem_complete,
    output logic [CNT_W-1:0]       m_elem_count,
    output logic                   m_run_last,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic              cfg_data
);

    localparam logic CFG_DROP_INCOMPLETE = 1'b0;
    localparam logic CFG_ALLOW_USER_TYPE = 1'b1;

    logic    drop_reg, drop_next;
    logic    allow_reg, allow_next;
    logic    in_accept;
    logic    push, pop, full, empty;
    bundle_t push_data, head;

    always_comb begin
        drop_next  = drop_reg;
        allow_next = allow_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DROP_INCOMPLETE: drop_next  = cfg_data;
                CFG_ALLOW_USER_TYPE: allow_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg  <= 1'b0;
            allow_reg <= 1'b0;
        end else begin
            drop_reg  <= drop_next;
            allow_reg <= allow_next;
        end
    end

    assign s_ready   = !full;
    assign in_accept = s_valid && s_ready;

    tes_front #(
        .MAX_TUPLE_BYTES (MAX_TUPLE_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .in_byte         (s_data_byte),
        .in_eoi          (s_end_of_input),
        .drop_incomplete (drop_reg),
        .allow_user_type (allow_reg),
        .push            (push),
        .push_data       (push_data)
    );

    tes_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    tes_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .empty           (empty),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rec_kind      (m_rec_kind),
        .m_elem_offset   (m_elem_offset),
        .m_elem_type     (m_elem_type),
        .m_elem_complete (m_elem_complete),
        .m_elem_count    (m_elem_count),
        .m_run_last      (m_run_last)
    );

endmodule

`default_nettype wire

FILE: src/tes_checker.sv
// Port-level checks for the tuple element splitter, bound to the top level.
`default_nettype none

module tes_checker import tes_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [KIND_W-1:0] m_rec_kind,
    input wire logic [OFF_W-1:0]  m_elem_offset,
    input wire logic [TYPE_W-1:0] m_elem_type,
    input wire logic              m_elem_complete,
    input wire logic [CNT_W-1:0]  m_elem_count,
    input wire logic              m_run_last
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rec_kind) && $stable(m_elem_offset)
            && $stable(m_elem_count) && $stable(m_run_last))
        else $error("result beat changed while stalled");

    // a done record ends the run of its byte and carries only the count
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rec_kind == REC_DONE |->
            m_run_last && m_elem_offset == '0 && m_elem_type == TY_NULL && !m_elem_complete)
        else $error("malformed done record");

    // after a bad code nothing else comes from that byte
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rec_kind == REC_BAD |->
            m_run_last && m_elem_count == '0 && m_elem_offset[OFF_W-1:8] == '0)
        else $error("malformed error record");

    a_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rec_kind == REC_ELEM |->
            m_elem_count == '0 && m_elem_type <= TY_USER)
        else $error("malformed element record");

endmodule

bind tuple_element_splitter_top tes_checker u_tes_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_rec_kind      (m_rec_kind),
    .m_elem_offset   (m_elem_offset),
    .m_elem_type     (m_elem_type),
    .m_elem_complete (m_elem_complete),
    .m_elem_count    (m_elem_count),
    .m_run_last      (m_run_last)
);

`default_nettype wire

FILE: verif/tb_tuple_element_splitter_top.sv
// Self-checking testbench for the tuple element splitter: byte stream in, element records out.
module tb_tuple_element_splitter_top;
    import tes_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned BYTES_PER_PHASE = 92;

    localparam logic REG_DROP_INCOMPLETE = 1'b0;
    localparam logic REG_ALLOW_USER_TYPE = 1'b1;

    localparam logic [7:0] CODE_NULL       = 8'h00;
    localparam logic [7:0] CODE_BYTES      = 8'h01;
    localparam logic [7:0] CODE_UTF8       = 8'h02;
    localparam logic [7:0] CODE_INT_MIN    = 8'h0C;
    localparam logic [7:0] CODE_INT_ZERO   = 8'h14;
    localparam logic [7:0] CODE_INT_MAX    = 8'h1C;
    localparam logic [7:0] CODE_FLOAT      = 8'h20;
    localparam logic [7:0] CODE_DOUBLE     = 8'h21;
    localparam logic [7:0] CODE_BOOL_FALSE = 8'h26;
    localparam logic [7:0] CODE_BOOL_TRUE  = 8'h27;
    localparam logic [7:0] CODE_STAMP      = 8'h33;
    localparam logic [7:0] CODE_USER_MIN   = 8'h40;
    localparam logic [7:0] CODE_USER_MAX   = 8'h4F;
    localparam logic [7:0] STR_END         = 8'h00;
    localparam logic [7:0] STR_ESC         = 8'hFF;

    typedef enum logic [2:0] {
        ST_CODE, ST_FIXED, ST_STR, ST_STR_ZERO, ST_USER, ST_SKIP
    } parse_state_t;

    typedef struct packed {
        rec_t rec;
        logic last;
    } record_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [7:0]        s_data_byte    = '0;
    logic              s_end_of_input = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [KIND_W-1:0] m_rec_kind;
    logic [OFF_W-1:0]  m_elem_offset;
    logic [TYPE_W-1:0] m_elem_type;
    logic              m_elem_complete;
    logic [CNT_W-1:0]  m_elem_count;
    logic              m_run_last;
    logic              cfg_wr_en      = 1'b0;
    logic              cfg_index      = 1'b0;
    logic              cfg_data       = 1'b0;

    // Splitter state as predicted
    parse_state_t      pr_state = ST_CODE;
    logic [3:0]        pr_left  = '0;
    logic [16:0]       pr_pos   = '0;
    logic [OFF_W-1:0]  pr_start = '0;
    logic [TYPE_W-1:0] pr_type  = '0;
    logic [CNT_W-1:0]  pr_total = '0;
    logic              pr_body  = 1'b0;
    logic              opt_drop = 1'b0;
    logic              opt_user = 1'b0;

    record_t     beat_recs[$];
    record_t     pending_records[$];
    logic [7:0]  tuple_bytes[$];

    int unsigned fail_count     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;

    tuple_element_splitter_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rec_kind      (m_rec_kind),
        .m_elem_offset   (m_elem_offset),
        .m_elem_type     (m_elem_type),
        .m_elem_complete (m_elem_complete),
        .m_elem_count    (m_elem_count),
        .m_run_last      (m_run_last),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [3:0] int_len(input logic [7:0] code);
        logic [7:0] d;
        d = (code >= CODE_INT_ZERO) ? code - CODE_INT_ZERO : CODE_INT_ZERO - code;
        return d[3:0];
    endfunction

    function automatic void add_record(input rec_kind_t kind, input logic [OFF_W-1:0] off,
                                       input logic [TYPE_W-1:0] ety, input logic complete,
                                       input logic [CNT_W-1:0] cnt);
        record_t r;
        if (beat_recs.size() >= RECS_MAX)
            return;
        r.rec.kind     = kind;
        r.rec.offset   = off;
        r.rec.etype    = ety;
        r.rec.complete = complete;
        r.rec.count    = cnt;
        r.last         = 1'b0;
        beat_recs = {beat_recs, r};
    endfunction

    function automatic void report_element(input logic complete);
        if (!complete && opt_drop)
            return;
        if (pr_total != '1)
            pr_total = pr_total + CNT_W'(1);
        add_record(REC_ELEM, pr_start, pr_type, complete, '0);
    endfunction

    function automatic void open_fixed(input logic [TYPE_W-1:0] ety, input logic [3:0] len);
        pr_type = ety;
        if (len == 0) begin
            report_element(1'b1);
            pr_state = ST_CODE;
        end else begin
            pr_left  = len;
            pr_state = ST_FIXED;
        end
    endfunction

    function automatic void open_element(input logic [7:0] b);
        pr_start = pr_pos[OFF_W-1:0];
        if (b == CODE_NULL) begin
            open_fixed(TY_NULL, 4'd0);
        end else if (b == CODE_BYTES || b == CODE_UTF8) begin
            pr_type  = (b == CODE_BYTES) ? TY_BYTES : TY_UTF8;
            pr_body  = 1'b0;
            pr_state = ST_STR;
        end else if (b >= CODE_INT_MIN && b <= CODE_INT_MAX) begin
            open_fixed(TY_INT, int_len(b));
        end else if (b == CODE_FLOAT) begin
            open_fixed(TY_FLOAT, 4'd4);
        end else if (b == CODE_DOUBLE) begin
            open_fixed(TY_DOUBLE, 4'd8);
        end else if (b == CODE_BOOL_FALSE || b == CODE_BOOL_TRUE) begin
            open_fixed(TY_BOOL, 4'd0);
        end else if (b == CODE_STAMP) begin
            open_fixed(TY_STAMP, STAMP_BYTES);
        end else if (opt_user && b >= CODE_USER_MIN && b <= CODE_USER_MAX) begin
            pr_type = TY_USER;
            report_element(1'b1);
            pr_state = ST_USER;
        end else begin
            add_record(REC_BAD, {8'h00, b}, '0, 1'b0, '0);
            pr_state = ST_SKIP;
        end
    endfunction

    function automatic void clear_tuple();
        pr_state = ST_CODE;
        pr_left  = '0;
        pr_pos   = '0;
        pr_start = '0;
        pr_type  = '0;
        pr_total = '0;
        pr_body  = 1'b0;
    endfunction

    function automatic void close_tuple();
        if (pr_state == ST_SKIP) begin
            clear_tuple();
            return;
        end
        if (pr_state == ST_FIXED)
            report_element(1'b0);
        else if (pr_state == ST_STR)
            report_element(pr_body);
        else if (pr_state == ST_STR_ZERO)
            report_element(1'b1);
        add_record(REC_DONE, '0, '0, 1'b0, pr_total);
        clear_tuple();
    endfunction

    // Work out every record that one accepted byte causes and queue them.
    function automatic void split_byte(input logic [7:0] b, input logic eoi);
        record_t r;
        beat_recs.delete();
        if (pr_pos < 17'(MAX_TUPLE_BYTES_DEF)) begin
            case (pr_state)
                ST_CODE: open_element(b);
                ST_FIXED: begin
                    if (pr_left != 0)
                        pr_left = pr_left - 4'd1;
                    if (pr_left == 0) begin
                        report_element(1'b1);
                        pr_state = ST_CODE;
                    end
                end
                ST_STR: begin
                    if (b == STR_END)
                        pr_state = ST_STR_ZERO;
                    else
                        pr_body = 1'b1;
                end
                ST_STR_ZERO: begin
                    if (b == STR_ESC) begin
                        pr_state = ST_STR;
                        pr_body  = 1'b0;
                    end else begin
                        report_element(1'b1);
                        pr_state = ST_CODE;
                        open_element(b);
                    end
                end
                default: ;
            endcase
            pr_pos = pr_pos + 17'd1;
        end
        if (eoi)
            close_tuple();
        for (int i = 0; i < beat_recs.size(); i++) begin
            r      = beat_recs[i];
            r.last = (i == beat_recs.size() - 1);
            pending_records = {pending_records, r};
        end
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin : check_records
        record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record: kind %0d offset %0d type %0d count %0d",
                       m_rec_kind, m_elem_offset, m_elem_type, m_elem_count);
                fail_count++;
            end else begin
                want = pending_records.pop_front();
                if (m_rec_kind !== want.rec.kind) begin
                    $error("rec_kind: expected %0d, got %0d", want.rec.kind, m_rec_kind);
                    fail_count++;
                end
                if (m_elem_offset !== want.rec.offset) begin
                    $error("elem_offset: expected %0d, got %0d", want.rec.offset, m_elem_offset);
                    fail_count++;
                end
                if (m_elem_type !== want.rec.etype) begin
                    $error("elem_type: expected %0d, got %0d", want.rec.etype, m_elem_type);
                    fail_count++;
                end
                if (m_elem_complete !== want.rec.complete) begin
                    $error("elem_complete: expected %0d, got %0d",
                           want.rec.complete, m_elem_complete);
                    fail_count++;
                end
                if (m_elem_count !== want.rec.count) begin
                    $error("elem_count: expected %0d, got %0d", want.rec.count, m_elem_count);
                    fail_count++;
                end
                if (m_run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_run_last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        split_byte(b, eoi);
    endtask

    task automatic send_tuple();
        int n;
        n = tuple_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(tuple_bytes[i], i == n - 1);
        tuple_bytes.delete();
    endtask

    // Drop valid, let every expected record arrive, then let the pipe settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic drop, input logic user_ok);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DROP_INCOMPLETE;
        cfg_data  <= drop;
        @(posedge aclk);
        opt_drop = drop;
        cfg_index <= REG_ALLOW_USER_TYPE;
        cfg_data  <= user_ok;
        @(posedge aclk);
        opt_user = user_ok;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        tuple_bytes = {tuple_bytes, b};
    endfunction

    function automatic void push_body(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            append_byte(8'($urandom_range(255)));
    endfunction

    // Append one well-formed element with random content.
    function automatic void add_element();
        int unsigned n;
        logic [7:0]  code;
        case ($urandom_range(8))
            0: append_byte(CODE_NULL);
            1: append_byte($urandom_range(1) ? CODE_BOOL_TRUE : CODE_BOOL_FALSE);
            2, 3: begin
                append_byte($urandom_range(1) ? CODE_UTF8 : CODE_BYTES);
                n = $urandom_range(5);
                for (int unsigned i = 0; i < n; i++) begin
                    if ($urandom_range(3) == 0) begin
                        append_byte(STR_END);
                        append_byte(STR_ESC);
                    end else begin
                        append_byte(8'($urandom_range(255, 1)));
                    end
                end
                append_byte(STR_END);
            end
            4, 5: begin
                code = 8'($urandom_range(CODE_INT_MAX, CODE_INT_MIN));
                append_byte(code);
                push_body(32'(int_len(code)));
            end
            6: begin
                append_byte(CODE_FLOAT);
                push_body(4);
            end
            7: begin
                append_byte(CODE_DOUBLE);
                push_body(8);
            end
            default: begin
                append_byte(CODE_STAMP);
                push_body(32'(STAMP_BYTES));
            end
        endcase
    endfunction

    // A few whole elements, then one of the ways a tuple can end.
    function automatic void build_tuple();
        int unsigned n;
        logic [7:0]  code;
        n = $urandom_range(4);
        for (int unsigned i = 0; i < n; i++)
            add_element();
        case ($urandom_range(6))
            0: if (tuple_bytes.size() == 0) add_element();
            1: begin
                case ($urandom_range(3))
                    0: begin code = CODE_FLOAT;  n = 4; end
                    1: begin code = CODE_DOUBLE; n = 8; end
                    2: begin code = CODE_STAMP;  n = 32'(STAMP_BYTES); end
                    default: begin
                        code = $urandom_range(1) ? CODE_INT_MIN : CODE_INT_MAX;
                        n = 32'(int_len(code));
                    end
                endcase
                append_byte(code);
                push_body($urandom_range(n - 1));
            end
            2: append_byte($urandom_range(1) ? CODE_UTF8 : CODE_BYTES);
            3: begin
                append_byte($urandom_range(1) ? CODE_UTF8 : CODE_BYTES);
                n = $urandom_range(3);
                for (int unsigned i = 0; i < n; i++)
                    append_byte(8'($urandom_range(255, 1)));
                append_byte(STR_END);
                append_byte(STR_ESC);
            end
            4: begin
                append_byte($urandom_range(1) ? CODE_UTF8 : CODE_BYTES);
                n = $urandom_range(3, 1);
                for (int unsigned i = 0; i < n; i++)
                    append_byte(8'($urandom_range(255, 1)));
            end
            5: begin
                append_byte(8'($urandom_range(CODE_USER_MAX, CODE_USER_MIN)));
                push_body($urandom_range(5));
            end
            default: begin
                // pick a code outside every known class
                do
                    code = 8'($urandom_range(255));
                while (code <= CODE_UTF8 || (code >= CODE_INT_MIN && code <= CODE_INT_MAX) ||
                       code == CODE_FLOAT || code == CODE_DOUBLE || code == CODE_BOOL_FALSE ||
                       code == CODE_BOOL_TRUE || code == CODE_STAMP ||
                       (code >= CODE_USER_MIN && code <= CODE_USER_MAX));
                append_byte(code);
                push_body($urandom_range(4));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // fixed kinds back to back, an escaped string, then a string cut at its code
        tuple_bytes = '{CODE_NULL, CODE_BOOL_FALSE, CODE_BOOL_TRUE, CODE_INT_ZERO,
                        CODE_INT_ZERO + 8'd1, 8'hFF, CODE_BYTES, 8'h41, STR_END, STR_ESC,
                        STR_END, CODE_UTF8};
        send_tuple();
        tuple_bytes = '{CODE_INT_MIN, 8'hFF};
        send_tuple();
        tuple_bytes = '{CODE_UTF8, STR_END, STR_ESC};
        send_tuple();
        tuple_bytes = '{CODE_BYTES, 8'h7A, STR_END};
        send_tuple();
        tuple_bytes = '{CODE_BYTES, 8'h7A};
        send_tuple();
        // user codes are unknown while not allowed
        tuple_bytes = '{CODE_USER_MIN, 8'h55};
        send_tuple();
        wait_idle();
    endtask

    task automatic test_directed_options();
        set_config(1'b1, 1'b1);
        tuple_bytes = '{CODE_INT_MAX, 8'h01};
        send_tuple();
        tuple_bytes = '{CODE_USER_MAX, STR_END, STR_ESC};
        send_tuple();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned n;
        for (int unsigned ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            set_config(ph[0], ph[1]);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                if ($urandom_range(4) != 0) begin
                    build_tuple();
                    sent += tuple_bytes.size();
                    send_tuple();
                end else begin
                    n = $urandom_range(8, 1);
                    for (int unsigned i = 0; i < n; i++)
                        send_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
                    sent += n;
                end
            end
            // close whatever the noise left open
            send_byte(8'($urandom_range(255)), 1'b1);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_byte(i[0] ? CODE_BOOL_FALSE : CODE_NULL, i == 39);
        wait_idle();
    endtask

    initial begin
        clear_tuple();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_defaults();
        test_directed_options();
        test_random_traffic();
        test_backpressure();
        sink_stall_pct = 0;
        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
